// ===== src/ssd_pkg.sv =====
// ----------------------------------------------------------------------------
// ssd_pkg: shared types and constants for the seven-segment scan driver
// Request codes, field widths and the character font used by the scanner.
// ----------------------------------------------------------------------------
package ssd_pkg;

  localparam int unsigned DIGIT_W      = 4;
  localparam int unsigned SEGMENT_W    = 3;
  localparam int unsigned PATTERN_W    = 8;
  localparam int unsigned BRIGHT_W     = 8;
  localparam int unsigned HEX_W        = 32;
  localparam int unsigned CHAR_W       = 8;
  localparam int unsigned FONT_LEN     = 43;
  localparam int unsigned FONT_IDX_W   = 6;

  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 8'd64;
  localparam logic [CHAR_W-1:0]   FONT_BASE    = 8'd48;  // '0'
  localparam logic [CHAR_W-1:0]   FONT_END     = 8'd91;  // one past 'Z'
  localparam logic [FONT_IDX_W-1:0] LETTER_SKIP = 6'd7;  // ':' .. '@' skipped

  typedef enum logic [1:0] {
    REQ_TICK = 2'd0,
    REQ_CHAR = 2'd1,
    REQ_HEX  = 2'd2
  } req_type_e;

  typedef logic [PATTERN_W-1:0] pattern_t;

  localparam pattern_t FONT [FONT_LEN] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F,
    8'h09, 8'h09, 8'h61, 8'h41, 8'h43, 8'h4B, 8'h5F,
    8'h77, 8'h7C, 8'h58, 8'h5E, 8'h79, 8'h71, 8'h3D,
    8'h74, 8'h10, 8'h0E, 8'h70, 8'h38, 8'h49, 8'h54,
    8'h5C, 8'h73, 8'h67, 8'h50, 8'h6D, 8'h78, 8'h3E,
    8'h62, 8'h6A, 8'h76, 8'h6E, 8'h5B
  };

  // ASCII '0'..'Z' through the font, anything else blank
  function automatic pattern_t char_glyph(logic [CHAR_W-1:0] code);
    logic [CHAR_W-1:0] offs;
    offs = code - FONT_BASE;
    if (code < FONT_BASE || code >= FONT_END) begin
      return '0;
    end
    return FONT[offs[FONT_IDX_W-1:0]];
  endfunction

  // nibble to glyph, A-F jump over the punctuation entries
  function automatic pattern_t hex_glyph(logic [3:0] nib);
    logic [FONT_IDX_W-1:0] idx;
    idx = {2'b00, nib};
    if (nib >= 4'd10) begin
      idx = idx + LETTER_SKIP;
    end
    return FONT[idx];
  endfunction

endpackage

// ===== src/seven_segment_scan_driver.sv =====
// ----------------------------------------------------------------------------
// seven_segment_scan_driver: segment-major multiplexed display scanner
// Frame store, font conversion and scan counters with a registered result.
// ----------------------------------------------------------------------------
// One transaction is taken per clock and its result appears in the output
// register in the next cycle; throughput is one item per cycle, limited only by
// the output register handshake (input is ready whenever that register is
// empty or being drained). A tick transaction reports the lines for the
// current scan position and then advances the dwell, digit and segment
// counters; character and hex transactions update the frame store and report
// the current position with strobe and glow low. cfg_we_i/cfg_wdata_i write
// brightness, by the user only while idle (unenforced); zero darkens the display.
module seven_segment_scan_driver #(
  parameter int unsigned DIGITS   = 16,
  parameter int unsigned SEGMENTS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [ssd_pkg::BRIGHT_W-1:0]      cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [1:0]                        req_type_i,
  input  logic [ssd_pkg::DIGIT_W-1:0]       position_i,
  input  logic [ssd_pkg::CHAR_W-1:0]        char_code_i,
  input  logic [ssd_pkg::HEX_W-1:0]         hex_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [ssd_pkg::DIGIT_W-1:0]       digit_select_o,
  output logic [ssd_pkg::SEGMENT_W-1:0]     segment_select_o,
  output logic                              latch_strobe_o,
  output logic                              glow_on_o
);

  localparam int unsigned DIG_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;
  localparam int unsigned SEG_W = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam logic [DIG_W-1:0] LAST_DIG = DIG_W'(DIGITS - 1);
  localparam logic [SEG_W-1:0] LAST_SEG = SEG_W'(SEGMENTS - 1);

  logic [ssd_pkg::BRIGHT_W-1:0] bright_q;
  ssd_pkg::pattern_t            frame_q [DIGITS];
  ssd_pkg::pattern_t            frame_d [DIGITS];
  logic [DIG_W-1:0]             dig_q, dig_d;
  logic [SEG_W-1:0]             seg_q, seg_d;
  logic [ssd_pkg::BRIGHT_W-1:0] dwell_q, dwell_d;

  logic                            out_valid_q, out_valid_d;
  logic [ssd_pkg::DIGIT_W-1:0]     dsel_q, dsel_d;
  logic [ssd_pkg::SEGMENT_W-1:0]   ssel_q, ssel_d;
  logic                            strobe_q, strobe_d;
  logic                            glow_q, glow_d;

  logic                         in_fire;
  logic [ssd_pkg::BRIGHT_W:0]   dwell_next;
  logic [ssd_pkg::BRIGHT_W:0]   dwell_len;
  logic [2*ssd_pkg::HEX_W-1:0]  hex_ext;
  ssd_pkg::pattern_t            cur_pat;

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign in_fire    = in_valid_i & in_ready_o;

  assign cur_pat    = frame_q[dig_q];
  assign dwell_next = {1'b0, dwell_q} + 9'd1;
  assign dwell_len  = (bright_q == '0) ? 9'd1 : {1'b0, bright_q};
  assign hex_ext    = {{ssd_pkg::HEX_W{1'b0}}, hex_value_i};

  always_comb begin
    frame_d  = frame_q;
    dig_d    = dig_q;
    seg_d    = seg_q;
    dwell_d  = dwell_q;
    dsel_d   = dsel_q;
    ssel_d   = ssel_q;
    strobe_d = strobe_q;
    glow_d   = glow_q;
    out_valid_d = out_valid_q & ~out_ready_i;

    if (in_fire) begin
      out_valid_d = 1'b1;
      dsel_d   = ssd_pkg::DIGIT_W'(dig_q);
      ssel_d   = ssd_pkg::SEGMENT_W'(seg_q);
      strobe_d = 1'b0;
      glow_d   = 1'b0;
      case (req_type_i)
        ssd_pkg::REQ_TICK: begin
          strobe_d = (dig_q == '0) && (dwell_q == '0);
          glow_d   = (bright_q != '0) && cur_pat[seg_q];
          if (dwell_next >= dwell_len) begin
            dwell_d = '0;
            if (dig_q == LAST_DIG) begin
              dig_d = '0;
              seg_d = (seg_q == LAST_SEG) ? '0 : seg_q + 1'b1;
            end else begin
              dig_d = dig_q + 1'b1;
            end
          end else begin
            dwell_d = dwell_next[ssd_pkg::BRIGHT_W-1:0];
          end
        end
        ssd_pkg::REQ_CHAR: begin
          if ({1'b0, position_i} < 5'(DIGITS)) begin
            frame_d[position_i[DIG_W-1:0]] = ssd_pkg::char_glyph(char_code_i);
          end
        end
        ssd_pkg::REQ_HEX: begin
          // slots beyond the eighth get nibble zero
          for (int i = 0; i < DIGITS; i++) begin
            frame_d[i] = ssd_pkg::hex_glyph(hex_ext[4*i +: 4]);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bright_q    <= ssd_pkg::BRIGHT_RESET;
      dig_q       <= '0;
      seg_q       <= '0;
      dwell_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < DIGITS; i++) begin
        frame_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        bright_q <= cfg_wdata_i;
      end
      dig_q       <= dig_d;
      seg_q       <= seg_d;
      dwell_q     <= dwell_d;
      out_valid_q <= out_valid_d;
      frame_q     <= frame_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dsel_q   <= dsel_d;
    ssel_q   <= ssel_d;
    strobe_q <= strobe_d;
    glow_q   <= glow_d;
  end

  assign out_valid_o      = out_valid_q;
  assign digit_select_o   = dsel_q;
  assign segment_select_o = ssel_q;
  assign latch_strobe_o   = strobe_q;
  assign glow_on_o        = glow_q;

endmodule

// ===== src/ssd_checker.sv =====
// ----------------------------------------------------------------------------
// ssd_checker: port-level checks for the seven-segment scan driver
// Watches the handshakes and the reported scan position over time.
// ----------------------------------------------------------------------------
module ssd_checker #(
  parameter int unsigned DIGITS   = 16,
  parameter int unsigned SEGMENTS = 8
) (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [ssd_pkg::DIGIT_W-1:0]       digit_select_o,
  input logic [ssd_pkg::SEGMENT_W-1:0]     segment_select_o,
  input logic                              latch_strobe_o,
  input logic                              glow_on_o
);

  // result held steady while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(digit_select_o)
      && $stable(segment_select_o) && $stable(latch_strobe_o) && $stable(glow_on_o))
    else $error("result changed under stall");

  // an accepted transaction always yields a result next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted transaction produced no result");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty output");

  // strobe only at the start of a segment row
  a_strobe_dig0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && latch_strobe_o |-> digit_select_o == '0)
    else $error("latch strobe away from digit zero");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_select_o < DIGITS) && (segment_select_o < SEGMENTS))
    else $error("scan position out of range");

endmodule

bind seven_segment_scan_driver ssd_checker #(
  .DIGITS  (DIGITS),
  .SEGMENTS(SEGMENTS)
) u_ssd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .digit_select_o  (digit_select_o),
  .segment_select_o(segment_select_o),
  .latch_strobe_o  (latch_strobe_o),
  .glow_on_o       (glow_on_o)
);
